// ===== sv/isdq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants, scan tables and helper functions of the
// inverse scan / dequantizer. No dependencies.
package isdq_pkg;

  // Input op codes
  localparam logic [1:0] OP_COEF     = 2'd0;
  localparam logic [1:0] OP_INTRA_WT = 2'd1;
  localparam logic [1:0] OP_INTER_WT = 2'd2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SCALE_TYPE   = 3'd0;
  localparam logic [2:0] REG_SCALE_CODE   = 3'd1;
  localparam logic [2:0] REG_INTRA_MODE   = 3'd2;
  localparam logic [2:0] REG_DC_PRECISION = 3'd3;
  localparam logic [2:0] REG_ALT_SCAN     = 3'd4;

  localparam int BLOCK_SIZE    = 64;
  localparam int QUEUE_DEPTH   = 4;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [4:0] SCALE_CODE_RESET = 5'd1;

  // Request as seen on the input port
  typedef struct packed {
    logic [1:0]        op;
    logic [5:0]        position;
    logic signed [11:0] coef_in;
    logic [7:0]        weight;
    logic              end_block;
  } cmd_t;

  // One emitted coefficient
  typedef struct packed {
    logic [5:0]         raster_pos;
    logic signed [11:0] coef_out;
    logic               last;
  } result_t;

  // Classified request kinds held in the queue
  typedef enum logic [1:0] {
    KIND_COEF,
    KIND_INTRA_W,
    KIND_INTER_W
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         position;
    logic signed [11:0] coef;
    logic [7:0]         weight;
    logic               end_block;
  } item_t;

  // Configuration register set
  typedef struct packed {
    logic       scale_type;
    logic [4:0] scale_code;
    logic       intra_mode;
    logic [1:0] dc_precision;
    logic       alt_scan;
  } cfg_t;

  // Scan index for each raster position
  localparam logic [5:0] ZIGZAG_SCAN [64] = '{
    6'd0,  6'd1,  6'd5,  6'd6,  6'd14, 6'd15, 6'd27, 6'd28,
    6'd2,  6'd4,  6'd7,  6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
    6'd3,  6'd8,  6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
    6'd9,  6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
    6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
    6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
    6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
    6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63
  };

  localparam logic [5:0] ALT_SCAN [64] = '{
    6'd0,  6'd4,  6'd6,  6'd20, 6'd22, 6'd36, 6'd38, 6'd52,
    6'd1,  6'd5,  6'd7,  6'd21, 6'd23, 6'd37, 6'd39, 6'd53,
    6'd2,  6'd8,  6'd19, 6'd24, 6'd34, 6'd40, 6'd50, 6'd54,
    6'd3,  6'd9,  6'd18, 6'd25, 6'd35, 6'd41, 6'd51, 6'd55,
    6'd10, 6'd17, 6'd26, 6'd30, 6'd42, 6'd46, 6'd56, 6'd60,
    6'd11, 6'd16, 6'd27, 6'd31, 6'd43, 6'd47, 6'd57, 6'd61,
    6'd12, 6'd15, 6'd28, 6'd32, 6'd44, 6'd48, 6'd58, 6'd62,
    6'd13, 6'd14, 6'd29, 6'd33, 6'd45, 6'd49, 6'd59, 6'd63
  };

  localparam logic [6:0] NONLIN_SCALE [32] = '{
    7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,
    7'd8,  7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20, 7'd22,
    7'd24, 7'd28, 7'd32, 7'd36, 7'd40, 7'd44, 7'd48, 7'd52,
    7'd56, 7'd64, 7'd72, 7'd80, 7'd88, 7'd96, 7'd104, 7'd112
  };

  // Raster position -> scan index
  function automatic logic [5:0] scan_pos(input logic alt, input logic [5:0] idx);
    scan_pos = alt ? ALT_SCAN[idx] : ZIGZAG_SCAN[idx];
  endfunction

  // Quantizer scale from type and code
  function automatic logic [6:0] quant_scale(input logic typ, input logic [4:0] code);
    quant_scale = typ ? NONLIN_SCALE[code] : {1'b0, code, 1'b0};
  endfunction

  // Clamp to the 12-bit signed range
  function automatic logic [11:0] sat12(input logic signed [30:0] v);
    if (v > 31'sd2047) begin
      sat12 = 12'h7FF;
    end else if (v < -31'sd2048) begin
      sat12 = 12'h800;
    end else begin
      sat12 = v[11:0];
    end
  endfunction

endpackage

// ===== sv/isdq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/isdq_front.sv =====
`timescale 1ns / 1ps
// Front end: takes requests on the command port and classifies them for the queue.
// Depends on isdq_pkg.
module isdq_front (
  input  logic                 start,
  input  isdq_pkg::cmd_t       cmd,
  input  logic                 full,
  output logic                 busy,
  output logic                 push,
  output isdq_pkg::item_t      push_item
);

  logic accept;
  logic known;

  // Request taken whenever the queue has room
  assign busy   = full;
  assign accept = start && !busy;

  // Classify the op; the unused code is dropped here
  always_comb begin
    known          = 1'b1;
    push_item.kind = isdq_pkg::KIND_COEF;
    case (cmd.op)
      isdq_pkg::OP_COEF:     push_item.kind = isdq_pkg::KIND_COEF;
      isdq_pkg::OP_INTRA_WT: push_item.kind = isdq_pkg::KIND_INTRA_W;
      isdq_pkg::OP_INTER_WT: push_item.kind = isdq_pkg::KIND_INTER_W;
      default:               known = 1'b0;
    endcase
    push_item.position  = cmd.position;
    push_item.coef      = cmd.coef_in;
    push_item.weight    = cmd.weight;
    // end flag only matters on coefficients
    push_item.end_block = cmd.end_block && (cmd.op == isdq_pkg::OP_COEF);
  end

  assign push = accept && known;

endmodule

// ===== sv/isdq_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified requests between front and back end.
// Depends on isdq_pkg.
module isdq_queue #(
  parameter int DEPTH = isdq_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  isdq_pkg::item_t  push_item,
  input  logic             pop,
  output isdq_pkg::item_t  head,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  isdq_pkg::item_t entries [DEPTH];
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // No overflow or underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");

endmodule

// ===== sv/isdq_back.sv =====
`timescale 1ns / 1ps
// Back end: executes queued requests, holds the coefficient buffer and weight
// matrices, and runs the dequantization pipeline. Depends on isdq_pkg, isdq_ram.
module isdq_back (
  input  logic                clk,
  input  logic                rst,
  input  isdq_pkg::cfg_t      cfg,
  input  logic                empty,
  input  isdq_pkg::item_t     head,
  output logic                pop,
  output logic                strobe,
  output isdq_pkg::result_t   result
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic [63:0] coef_vld;
  logic        emit;
  logic [5:0]  scan_addr;

  logic        coef_we;
  logic        intra_we;
  logic        inter_we;
  logic [11:0] coef_rd;
  logic [7:0]  intra_rd;
  logic [7:0]  inter_rd;

  // Pipeline registers
  logic        a_valid, b_valid, c_valid;
  logic [5:0]  a_pos, b_pos, c_pos;
  logic        a_vld;
  logic [6:0]  scale_r;
  logic signed [22:0] b_m1;
  logic signed [30:0] c_m2;
  logic signed [11:0] b_q, c_q;
  logic        b_dc, c_dc;
  logic        b_qpos, c_qpos;
  logic        b_qneg, c_qneg;

  // Stage A signals
  logic signed [11:0] q;
  logic        q_pos, q_neg;
  logic [7:0]  w;
  logic signed [13:0] sgn14;
  logic signed [13:0] base;
  logic signed [22:0] m1;

  // Stage B/C signals
  logic signed [30:0] m2;
  logic [1:0]         dc_shift;
  logic signed [14:0] dc_val;
  logic signed [30:0] adj;
  logic signed [30:0] quo;
  logic signed [30:0] ac_val;
  isdq_pkg::result_t  res_next;

  // Request execution only while not emitting
  assign emit      = (state == ST_EMIT);
  assign pop       = (state == ST_IDLE) && !empty;
  assign coef_we   = pop && (head.kind == isdq_pkg::KIND_COEF);
  assign intra_we  = pop && (head.kind == isdq_pkg::KIND_INTRA_W);
  assign inter_we  = pop && (head.kind == isdq_pkg::KIND_INTER_W);
  assign scan_addr = isdq_pkg::scan_pos(cfg.alt_scan, cnt);

  isdq_ram #(.WIDTH(12), .DEPTH(isdq_pkg::BLOCK_SIZE)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (head.position),
    .wdata (head.coef),
    .raddr (scan_addr),
    .rdata (coef_rd)
  );

  isdq_ram #(.WIDTH(8), .DEPTH(isdq_pkg::BLOCK_SIZE)) u_intra_ram (
    .clk   (clk),
    .we    (intra_we),
    .waddr (head.position),
    .wdata (head.weight),
    .raddr (cnt),
    .rdata (intra_rd)
  );

  isdq_ram #(.WIDTH(8), .DEPTH(isdq_pkg::BLOCK_SIZE)) u_inter_ram (
    .clk   (clk),
    .we    (inter_we),
    .waddr (head.position),
    .wdata (head.weight),
    .raddr (cnt),
    .rdata (inter_rd)
  );

  // Stage A: coefficient and weight product
  always_comb begin
    q     = a_vld ? $signed(coef_rd) : 12'sd0;
    q_neg = q[11];
    q_pos = !q[11] && (q != 12'sd0);
    w     = cfg.intra_mode ? intra_rd : inter_rd;
    sgn14 = q_neg ? -14'sd1 : (q_pos ? 14'sd1 : 14'sd0);
    base  = $signed({q[11], q, 1'b0}) + (cfg.intra_mode ? 14'sd0 : sgn14);
    m1    = base * $signed({1'b0, w});
  end

  // Stage B: times quantizer scale
  assign m2 = b_m1 * $signed({1'b0, scale_r});

  // Stage C: divide by 32 toward zero, force odd, saturate; DC path aside
  always_comb begin
    dc_shift = 2'd3 - cfg.dc_precision;
    dc_val   = $signed({{3{c_q[11]}}, c_q}) <<< dc_shift;
    adj      = c_m2 + (c_m2[30] ? 31'sd31 : 31'sd0);
    quo      = adj >>> 5;
    ac_val   = quo;
    if ((c_qpos || c_qneg) && !quo[0]) begin
      ac_val = c_qpos ? quo - 31'sd1 : quo + 31'sd1;
    end
    res_next.raster_pos = c_pos;
    res_next.coef_out   = c_dc ? $signed(isdq_pkg::sat12({{16{dc_val[14]}}, dc_val}))
                               : $signed(isdq_pkg::sat12(ac_val));
    res_next.last       = (c_pos == isdq_pkg::LAST_POS);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    scale_r <= isdq_pkg::quant_scale(cfg.scale_type, cfg.scale_code);
    a_pos   <= cnt;
    a_vld   <= coef_vld[scan_addr];
    b_m1    <= m1;
    b_pos   <= a_pos;
    b_q     <= q;
    b_dc    <= cfg.intra_mode && (a_pos == 6'd0);
    b_qpos  <= q_pos;
    b_qneg  <= q_neg;
    c_m2    <= m2;
    c_pos   <= b_pos;
    c_q     <= b_q;
    c_dc    <= b_dc;
    c_qpos  <= b_qpos;
    c_qneg  <= b_qneg;
  end

  // Sequencer, buffer valid bits and registered outputs
  always_ff @(posedge clk) begin
    result <= res_next;
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      coef_vld <= '0;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      a_valid <= emit;
      b_valid <= a_valid;
      c_valid <= b_valid;
      strobe  <= c_valid;
      case (state)
        ST_IDLE: begin
          if (coef_we) begin
            coef_vld[head.position] <= 1'b1;
            if (head.end_block) begin
              state <= ST_EMIT;
              cnt   <= '0;
            end
          end
        end
        ST_EMIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == isdq_pkg::LAST_POS) begin
            state    <= ST_IDLE;
            coef_vld <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Buffer is empty once the last position has been read out
  a_buf_cleared: assert property (@(posedge clk) disable iff (rst)
      (emit && (cnt == isdq_pkg::LAST_POS)) |=> (coef_vld == '0))
    else $error("coefficient buffer not cleared after emission");
  // A block comes out as one unbroken run
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
      (strobe && !result.last) |=> strobe)
    else $error("gap inside a result run");
  // Blocks never abut without a gap
  a_run_gap: assert property (@(posedge clk) disable iff (rst)
      (strobe && result.last) |=> !strobe)
    else $error("result directly after last of block");

endmodule

// ===== sv/mpeg2_inverse_scan_dequant_core.sv =====
`timescale 1ns / 1ps
// Top level of the inverse scan / dequantizer: configuration registers and
// front end, queue and back end. Depends on isdq_pkg and all isdq_* modules.
//
// Usage:
//   Requests enter on cmd and are taken at a clock edge with start high and
//   busy low. op 0 stores a quantized coefficient at its scan index, ops 1
//   and 2 load an intra or non-intra weight at its raster index, op 3 is
//   taken and dropped. A coefficient with end_block set starts read-out.
//   Read-out gives 64 results in raster order on result, one per cycle, each
//   marked by strobe for one cycle; last flags raster position 63. The
//   coefficient buffer is empty again after the read-out.
//   Throughput is one request per cycle while busy is low. An end-of-block
//   request occupies the back end while it executes and while the read
//   counter steps through all 64 positions; meanwhile the request queue
//   (QUEUE_DEPTH entries) can fill, and then busy rises. The first result of
//   a block passes the queue, the sequencer state, the buffer read, two
//   multiplier stages and the output register. Results cannot be held off.
//   Registers must be written over the APB port only while no block is in
//   flight; the block itself does not enforce this. Reset clears the buffer,
//   the queue and the pipeline; weights stay undefined until loaded.
module mpeg2_inverse_scan_dequant_core #(
  parameter int QUEUE_DEPTH = isdq_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  // command channel
  input  logic                start,
  input  isdq_pkg::cmd_t      cmd,
  output logic                busy,
  // result channel
  output logic                strobe,
  output isdq_pkg::result_t   result,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  isdq_pkg::cfg_t  cfg;
  logic            scale_type;
  logic [4:0]      scale_code;
  logic            intra_mode;
  logic [1:0]      dc_precision;
  logic            alt_scan;
  logic            reg_wr;
  logic [2:0]      reg_idx;

  logic            full;
  logic            empty;
  logic            push;
  logic            pop;
  isdq_pkg::item_t push_item;
  isdq_pkg::item_t head;

  // APB register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_type   <= 1'b0;
      scale_code   <= isdq_pkg::SCALE_CODE_RESET;
      intra_mode   <= 1'b0;
      dc_precision <= 2'd0;
      alt_scan     <= 1'b0;
    end else if (reg_wr) begin
      case (reg_idx)
        isdq_pkg::REG_SCALE_TYPE:   scale_type   <= pwdata[0];
        isdq_pkg::REG_SCALE_CODE:   scale_code   <= pwdata[4:0];
        isdq_pkg::REG_INTRA_MODE:   intra_mode   <= pwdata[0];
        isdq_pkg::REG_DC_PRECISION: dc_precision <= pwdata[1:0];
        isdq_pkg::REG_ALT_SCAN:     alt_scan     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      isdq_pkg::REG_SCALE_TYPE:   prdata = {31'd0, scale_type};
      isdq_pkg::REG_SCALE_CODE:   prdata = {27'd0, scale_code};
      isdq_pkg::REG_INTRA_MODE:   prdata = {31'd0, intra_mode};
      isdq_pkg::REG_DC_PRECISION: prdata = {30'd0, dc_precision};
      isdq_pkg::REG_ALT_SCAN:     prdata = {31'd0, alt_scan};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg.scale_type   = scale_type;
  assign cfg.scale_code   = scale_code;
  assign cfg.intra_mode   = intra_mode;
  assign cfg.dc_precision = dc_precision;
  assign cfg.alt_scan     = alt_scan;

  isdq_front u_front (
    .start     (start),
    .cmd       (cmd),
    .full      (full),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  isdq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  isdq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ===== tb/sv/tb_mpeg2_inverse_scan_dequant_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the MPEG-2 inverse scan / dequantizer core.
// Needs isdq_pkg and mpeg2_inverse_scan_dequant_core; predicts every emitted
// coefficient and checks them in order.
module tb_mpeg2_inverse_scan_dequant_core;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int ITEM_TARGET   = 460;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_PRINTED   = 50;

  // scan index for each raster position
  localparam int ZZ_SCAN_IDX [64] = '{
    0,  1,  5,  6,  14, 15, 27, 28,
    2,  4,  7,  13, 16, 26, 29, 42,
    3,  8,  12, 17, 25, 30, 41, 43,
    9,  11, 18, 24, 31, 40, 44, 53,
    10, 19, 23, 32, 39, 45, 52, 54,
    20, 22, 33, 38, 46, 51, 55, 60,
    21, 34, 37, 47, 50, 56, 59, 61,
    35, 36, 48, 49, 57, 58, 62, 63
  };

  localparam int ALT_SCAN_IDX [64] = '{
    0,  4,  6,  20, 22, 36, 38, 52,
    1,  5,  7,  21, 23, 37, 39, 53,
    2,  8,  19, 24, 34, 40, 50, 54,
    3,  9,  18, 25, 35, 41, 51, 55,
    10, 17, 26, 30, 42, 46, 56, 60,
    11, 16, 27, 31, 43, 47, 57, 61,
    12, 15, 28, 32, 44, 48, 58, 62,
    13, 14, 29, 33, 45, 49, 59, 63
  };

  localparam int NONLINEAR_QSCALE [32] = '{
    0,  1,  2,  3,  4,  5,  6,  7,  8,  10, 12, 14, 16, 18,  20,  22,
    24, 28, 32, 36, 40, 44, 48, 52, 56, 64, 72, 80, 88, 96, 104, 112
  };

  // Tracks buffer, weight tables and registers; holds expected coefficients
  class dequant_scoreboard;
    logic signed [11:0]  coef_buf [64];
    logic [7:0]          intra_wt [64];
    logic [7:0]          inter_wt [64];
    isdq_pkg::cfg_t      cfg;
    isdq_pkg::result_t   expected_coefs [$];
    int                  errors;

    function new();
      foreach (coef_buf[i]) begin
        coef_buf[i] = '0;
        intra_wt[i] = '0;
        inter_wt[i] = '0;
      end
      cfg = '0;
      cfg.scale_code = 5'd1;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        isdq_pkg::REG_SCALE_TYPE:   cfg.scale_type   = data[0];
        isdq_pkg::REG_SCALE_CODE:   cfg.scale_code   = data[4:0];
        isdq_pkg::REG_INTRA_MODE:   cfg.intra_mode   = data[0];
        isdq_pkg::REG_DC_PRECISION: cfg.dc_precision = data[1:0];
        isdq_pkg::REG_ALT_SCAN:     cfg.alt_scan     = data[0];
        default: ;
      endcase
    endfunction

    function logic signed [11:0] clamp_12(int v);
      if (v > 2047) v = 2047;
      else if (v < -2048) v = -2048;
      return v[11:0];
    endfunction

    // dequantize one buffered coefficient for raster position r
    function logic signed [11:0] dequant(int r, int q);
      int s, w, qscale, v, dc_mult;
      s = (q > 0) ? 1 : ((q < 0) ? -1 : 0);
      qscale = cfg.scale_type ? NONLINEAR_QSCALE[cfg.scale_code]
                              : 2 * int'(cfg.scale_code);
      if (cfg.intra_mode) begin
        if (r == 0) begin
          dc_mult = 8 >> cfg.dc_precision;
          return clamp_12(q * dc_mult);
        end
        w = int'(intra_wt[r]);
        v = (2 * q * w * qscale) / 32;
      end else begin
        w = int'(inter_wt[r]);
        v = ((2 * q + s) * w * qscale) / 32;
      end
      // force odd toward zero
      if (s != 0 && v[0] == 1'b0) v = v - s;
      return clamp_12(v);
    endfunction

    function void note_request(isdq_pkg::cmd_t c);
      isdq_pkg::result_t e;
      int src;
      case (c.op)
        isdq_pkg::OP_INTRA_WT: intra_wt[c.position] = c.weight;
        isdq_pkg::OP_INTER_WT: inter_wt[c.position] = c.weight;
        isdq_pkg::OP_COEF: begin
          coef_buf[c.position] = c.coef_in;
          if (c.end_block) begin
            for (int r = 0; r < 64; r++) begin
              src = cfg.alt_scan ? ALT_SCAN_IDX[r] : ZZ_SCAN_IDX[r];
              e.raster_pos = r[5:0];
              e.coef_out   = dequant(r, int'(coef_buf[src]));
              e.last       = (r == 63);
              expected_coefs.push_back(e);
            end
            foreach (coef_buf[i]) coef_buf[i] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t ERROR %s", $time, msg);
    endtask

    task check_result(isdq_pkg::result_t got);
      isdq_pkg::result_t want;
      if (expected_coefs.size() == 0) begin
        report($sformatf("result with nothing expected, raster_pos %0d", got.raster_pos));
        return;
      end
      want = expected_coefs.pop_front();
      if (got.raster_pos !== want.raster_pos)
        report($sformatf("raster_pos %0d, want %0d", got.raster_pos, want.raster_pos));
      if (got.coef_out !== want.coef_out)
        report($sformatf("raster %0d coef_out %0d, want %0d",
                         want.raster_pos, got.coef_out, want.coef_out));
      if (got.last !== want.last)
        report($sformatf("raster %0d last %0b, want %0b",
                         want.raster_pos, got.last, want.last));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  isdq_pkg::cmd_t    cmd;
  logic              busy;
  logic              strobe;
  isdq_pkg::result_t result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  dequant_scoreboard sb = new();
  int items_sent = 0;
  int stall_cycles = 0;

  mpeg2_inverse_scan_dequant_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(result);
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int gap_len(bit no_gap);
    if (no_gap) return 0;
    case ($urandom_range(0, 19))
      0:             return $urandom_range(10, 40);
      1, 2, 3, 4, 5: return $urandom_range(1, 3);
      default:       return 0;
    endcase
  endfunction

  function automatic logic signed [11:0] rand_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
      1, 2:    return r[11:0];
      3:       return '0;
      default: begin
        r = $urandom_range(0, 32) - 16;
        return r[11:0];
      end
    endcase
  endfunction

  function automatic logic [31:0] with_junk(logic [31:0] val, logic [31:0] mask);
    return ($urandom & ~mask) | (val & mask);
  endfunction

  function automatic isdq_pkg::cfg_t rand_cfg();
    isdq_pkg::cfg_t c;
    c.scale_type = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       c.scale_code = 5'd31;
      1:       c.scale_code = 5'd1;
      2:       c.scale_code = 5'd0;
      default: c.scale_code = 5'($urandom_range(1, 31));
    endcase
    c.intra_mode   = 1'($urandom_range(0, 1));
    c.dc_precision = 2'($urandom_range(0, 3));
    c.alt_scan     = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // present one request and hold it until busy is low at a rising edge
  task automatic send_request(isdq_pkg::cmd_t c);
    @(negedge clk);
    start = 1'b1;
    cmd   = c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(c);
    if (c.op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_cmd(logic [1:0] op, logic [5:0] pos, logic signed [11:0] coef,
                          logic [7:0] w, bit eob);
    isdq_pkg::cmd_t c;
    c.op        = op;
    c.position  = pos;
    c.coef_in   = coef;
    c.weight    = w;
    c.end_block = eob;
    send_request(c);
  endtask

  // wait until every expected result is back and the pipeline has drained
  task automatic wait_drained();
    idle_cycles(1);
    while (sb.expected_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // all registers are rewritten at every change, junk above each field
  task automatic apply_config(isdq_pkg::cfg_t c);
    wait_drained();
    reg_write(isdq_pkg::REG_SCALE_TYPE,   with_junk(32'(c.scale_type),   32'h1));
    reg_write(isdq_pkg::REG_SCALE_CODE,   with_junk(32'(c.scale_code),   32'h1F));
    reg_write(isdq_pkg::REG_INTRA_MODE,   with_junk(32'(c.intra_mode),   32'h1));
    reg_write(isdq_pkg::REG_DC_PRECISION, with_junk(32'(c.dc_precision), 32'h3));
    reg_write(isdq_pkg::REG_ALT_SCAN,     with_junk(32'(c.alt_scan),     32'h1));
    reg_write(REG_UNUSED,                 $urandom);
  endtask

  // ignored op or weight reload with a random end flag
  task automatic send_noise(bit no_gap);
    logic [1:0] op;
    case ($urandom_range(0, 2))
      0:       op = OP_UNUSED;
      1:       op = isdq_pkg::OP_INTRA_WT;
      default: op = isdq_pkg::OP_INTER_WT;
    endcase
    send_cmd(op, 6'($urandom_range(0, 63)), rand_coef(), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    idle_cycles(gap_len(no_gap));
  endtask

  // one 8x8 block: n coefficients, the last one carrying end_block
  task automatic send_block(int n, bit in_order, bit no_gap);
    logic [5:0] pos;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) send_noise(no_gap);
      pos = in_order ? k[5:0] : 6'($urandom_range(0, 63));
      send_cmd(isdq_pkg::OP_COEF, pos, rand_coef(), 8'($urandom_range(0, 255)),
               k == n - 1);
      idle_cycles(gap_len(no_gap));
    end
  endtask

  initial begin
    bit no_gap;
    int n;
    rst     = 1'b1;
    start   = 1'b0;
    cmd     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // load both weight matrices fully, with the extremes at positions 1 and 2
    for (int r = 0; r < 64; r++) begin
      send_cmd(isdq_pkg::OP_INTRA_WT, r[5:0], rand_coef(),
               (r == 1) ? 8'd255 : (r == 2) ? 8'd0 : 8'($urandom_range(0, 255)), 1'b0);
      send_cmd(isdq_pkg::OP_INTER_WT, r[5:0], rand_coef(),
               (r == 1) ? 8'd255 : (r == 2) ? 8'd0 : 8'($urandom_range(0, 255)), 1'b0);
    end

    // cfg fields: scale_type, scale_code, intra_mode, dc_precision, alt_scan
    // non-intra, largest linear scale, extreme coefficients
    apply_config('{1'b0, 5'd31, 1'b0, 2'd0, 1'b0});
    send_cmd(isdq_pkg::OP_COEF, 6'd0,  12'sh7FF, 8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd1,  12'sh800, 8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd2,  -12'sd1,  8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd63, 12'sd1,   8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd5,  12'sd0,   8'd0, 1'b1);
    // end flag on ignored op and on weight loads does nothing
    send_cmd(OP_UNUSED,             6'd63, 12'sh7FF, 8'd255, 1'b1);
    send_cmd(isdq_pkg::OP_INTRA_WT, 6'd2,  12'sd0,   8'd0,   1'b1);
    send_cmd(isdq_pkg::OP_INTER_WT, 6'd1,  12'sd0,   8'd255, 1'b1);

    // intra, nonlinear scale, alternate scan, DC times 8 saturates
    apply_config('{1'b1, 5'd31, 1'b1, 2'd0, 1'b1});
    send_cmd(isdq_pkg::OP_COEF, 6'd0,  12'sh7FF, 8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd1,  12'sh800, 8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd63, -12'sd1,  8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd10, 12'sd3,   8'd0, 1'b1);

    // intra with zero scale code: AC collapses to +-1, DC times 1
    apply_config('{1'b0, 5'd0, 1'b1, 2'd3, 1'b0});
    send_cmd(isdq_pkg::OP_COEF, 6'd0, 12'sh800, 8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd5, 12'sd7,   8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd6, -12'sd7,  8'd0, 1'b1);

    // remaining DC precisions
    apply_config('{1'b1, 5'd1, 1'b1, 2'd1, 1'b0});
    send_cmd(isdq_pkg::OP_COEF, 6'd0, -12'sd5, 8'd0, 1'b1);
    apply_config('{1'b0, 5'd1, 1'b1, 2'd2, 1'b1});
    send_cmd(isdq_pkg::OP_COEF, 6'd0, 12'sd255, 8'd0, 1'b1);

    // non-intra with zero scale code
    apply_config('{1'b1, 5'd0, 1'b0, 2'd0, 1'b0});
    send_cmd(isdq_pkg::OP_COEF, 6'd3, 12'sd5, 8'd0, 1'b0);
    send_cmd(isdq_pkg::OP_COEF, 6'd4, 12'sd0, 8'd0, 1'b1);

    // random phases: new settings, then a run of blocks
    while (items_sent < ITEM_TARGET) begin
      apply_config(rand_cfg());
      no_gap = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        if (items_sent < ITEM_TARGET) begin
          case ($urandom_range(0, 9))
            0: send_block(64, 1'b1, no_gap);
            1: begin
              n = $urandom_range(9, 40);
              send_block(n, 1'b0, no_gap);
            end
            default: begin
              n = $urandom_range(1, 8);
              send_block(n, 1'b0, no_gap);
            end
          endcase
        end
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.expected_coefs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
